>>> rtl/core/smmn_pkg.sv
// Shared widths, reset values, register indexes and sequencer states for the
// slice min/max normalizer. No dependencies; used by every file in rtl/core.
package smmn_pkg;

   localparam int PIX_W   = 32;                // signed pixel word
   localparam int BYTE_W  = 8;                 // output byte and range registers
   localparam int SPAN_W  = BYTE_W + 1;        // signed out_max - out_min
   localparam int DIFF_W  = PIX_W + 1;         // signed pixel - slice minimum
   localparam int COEF_W  = SPAN_W + 1;        // signed small multiplier operand
   localparam int PROD_W  = DIFF_W + COEF_W;   // signed product
   localparam int ACC_W   = PROD_W + 1;        // signed numerator
   localparam int MAG_W   = ACC_W - 1;         // numerator magnitude
   localparam int DEN_W   = PIX_W + 1;         // 2 * divisor
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic signed [PIX_W-1:0] RUN_MIN_INIT = {1'b0, {(PIX_W-1){1'b1}}};
   localparam logic signed [PIX_W-1:0] RUN_MAX_INIT = {1'b1, {(PIX_W-1){1'b0}}};
   localparam logic [BYTE_W-1:0] OUT_MIN_RST = 8'h00;
   localparam logic [BYTE_W-1:0] OUT_MAX_RST = 8'hFF;

   typedef enum logic {
      REG_OUT_MIN = 1'b0,
      REG_OUT_MAX = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_ACCUM = 1'b0,
      CMD_EMIT  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_BASE,
      ST_MUL_DIFF,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/core/smmn_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on smmn_pkg for default widths and the status struct.
module smmn_divider
   import smmn_pkg::*;
#(
   parameter int DIVIDEND_W = MAG_W,
   parameter int DIVISOR_W  = DEN_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output div_status_type        status
);

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  fits;

   // remainder stays below the divisor, so the shifted value fits one extra bit
   assign rem_shift = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_LAST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? rem_sub : rem_shift;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/core/slice_minmax_normalizer_unit.sv
// Top level of the slice min/max normalizer: request/response channels, APB
// registers, sequencer and shared multiplier. Depends on smmn_pkg, smmn_divider.
//
//  channel   direction  ports                                    transfer
//  request   in         req_valid/req_ready, cmd, pixel, end     valid & ready
//  response  out        rsp_valid/rsp_ready, out_byte, out_last  valid & ready
//  config    in         psel, penable, pwrite, paddr, pwdata     psel & penable
//
// A pass-one request (cmd 0) gives no response. A pass-two request on a blank
// slice goes straight to the emit state, else it makes two passes through the
// shared multiplier, a divider load, 43 quotient bits one per cycle in the
// serial divider until it flags done, then the emit state. Synchronous
// active-high reset restores the register defaults and the empty-slice state.
// A full response register holds the sequencer in its emit state until the
// response is taken; no new request is taken meanwhile.
module slice_minmax_normalizer_unit
   import smmn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic signed [PIX_W-1:0] req_pixel,
   input  logic                    req_slice_end,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BYTE_W-1:0]       rsp_out_byte,
   output logic                    rsp_out_last,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   seq_state_type state_ff, state_in;

   logic [BYTE_W-1:0]         out_min_ff, out_max_ff;
   logic signed [PIX_W-1:0]   run_min_ff, run_min_in;
   logic signed [PIX_W-1:0]   run_max_ff, run_max_in;
   logic [PIX_W-1:0]          scale_ff, scale_in;
   logic signed [PIX_W-1:0]   slice_min_ff, slice_min_in;
   logic                      blank_ff, blank_in;
   logic signed [SPAN_W-1:0]  span_ff, span_in;
   logic [BYTE_W-1:0]         omin_ff, omin_in;

   logic signed [PIX_W-1:0]   pix_ff;
   logic                      last_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [BYTE_W-1:0]         byte_ff, byte_in;
   logic                      rlast_ff;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      accept;
   logic                      cfg_write;
   logic                      div_start;
   logic                      rsp_load;
   logic                      blank_now;
   logic signed [PIX_W-1:0]   new_min, new_max;

   logic signed [DIFF_W-1:0]  mul_a;
   logic signed [COEF_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      num_neg;
   logic [ACC_W-1:0]          num_abs;
   logic [MAG_W-1:0]          quotient;
   div_status_type            div_status;
   logic [BYTE_W-1:0]         q_byte;

   assign accept    = req_valid & req_ready;
   assign cfg_write = psel & penable & pwrite & pready;
   assign blank_now = blank_ff | (scale_ff == '0);

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_min_ff <= OUT_MIN_RST;
         out_max_ff <= OUT_MAX_RST;
      end else if (cfg_write) begin
         unique case (reg_index_type'(paddr[2]))
            REG_OUT_MIN: out_min_ff <= pwdata[BYTE_W-1:0];
            REG_OUT_MAX: out_max_ff <= pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_OUT_MIN: prdata = {{(DATA_W-BYTE_W){1'b0}}, out_min_ff};
         REG_OUT_MAX: prdata = {{(DATA_W-BYTE_W){1'b0}}, out_max_ff};
         default:     prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // ---------------- pass one: running extremes ----------------
   assign new_min = (req_pixel < run_min_ff) ? req_pixel : run_min_ff;
   assign new_max = (req_pixel > run_max_ff) ? req_pixel : run_max_ff;

   always_comb begin
      run_min_in   = run_min_ff;
      run_max_in   = run_max_ff;
      scale_in     = scale_ff;
      slice_min_in = slice_min_ff;
      blank_in     = blank_ff;
      span_in      = span_ff;
      omin_in      = omin_ff;
      if (accept && (cmd_type'(req_cmd) == CMD_ACCUM)) begin
         run_min_in = new_min;
         run_max_in = new_max;
         if (req_slice_end) begin
            slice_min_in = new_min;
            omin_in      = out_min_ff;
            span_in      = $signed({1'b0, out_max_ff}) - $signed({1'b0, out_min_ff});
            blank_in     = (new_max == new_min);
            scale_in     = (new_max == new_min) ? '0 : PIX_W'(new_max - new_min);
            run_min_in   = RUN_MIN_INIT;
            run_max_in   = RUN_MAX_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff   <= RUN_MIN_INIT;
         run_max_ff   <= RUN_MAX_INIT;
         scale_ff     <= '0;
         slice_min_ff <= '0;
         blank_ff     <= 1'b1;
         span_ff      <= '0;
         omin_ff      <= '0;
      end else begin
         run_min_ff   <= run_min_in;
         run_max_ff   <= run_max_in;
         scale_ff     <= scale_in;
         slice_min_ff <= slice_min_in;
         blank_ff     <= blank_in;
         span_ff      <= span_in;
         omin_ff      <= omin_in;
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd_type'(req_cmd) == CMD_EMIT)) begin
               state_in = blank_now ? ST_EMIT : ST_MUL_BASE;
            end
         end
         ST_MUL_BASE: state_in = ST_MUL_DIFF;
         ST_MUL_DIFF: state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req_ready = 1'b1;
         ST_DIV_LOAD: div_start = 1'b1;
         ST_EMIT:     rsp_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- pass two: numerator through the shared multiplier ----------------
   // base term (2*omin+1)*scale first, then 2*span*(pixel-min) added on
   always_comb begin
      if (state_ff == ST_MUL_BASE) begin
         mul_a = $signed({1'b0, scale_ff});
         mul_b = $signed({1'b0, omin_ff, 1'b1});
      end else begin
         mul_a = diff_ff;
         mul_b = $signed({span_ff, 1'b0});
      end
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ST_MUL_BASE) begin
         acc_in = ACC_W'(prod);
      end else if (state_ff == ST_MUL_DIFF) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= req_pixel;
         last_ff <= req_slice_end;
      end
      if (state_ff == ST_MUL_BASE) begin
         diff_ff <= DIFF_W'(pix_ff) - DIFF_W'(slice_min_ff);
      end
      acc_ff <= acc_in;
   end

   assign num_neg = acc_ff[ACC_W-1];
   assign num_abs = num_neg ? (~acc_ff + 1'b1) : acc_ff;

   smmn_divider #(
      .DIVIDEND_W (MAG_W),
      .DIVISOR_W  (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_abs[MAG_W-1:0]),
      .divisor  ({scale_ff, 1'b0}),
      .quotient (quotient),
      .status   (div_status)
   );

   // truncate toward zero: negate the magnitude's quotient, keep the low byte
   assign q_byte = num_neg ? (~quotient[BYTE_W-1:0] + 1'b1) : quotient[BYTE_W-1:0];

   // ---------------- response register ----------------
   always_comb begin
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         byte_in      = blank_now ? omin_ff : q_byte;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (rsp_load) begin
         rlast_ff <= last_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = rlast_ff;

endmodule

>>> tb/sv/tb_slice_minmax_normalizer_unit.sv
`timescale 1ns / 1ps
// Testbench for slice_minmax_normalizer_unit: directed requests and range settings,
// then random two-pass slices and noise; checked by a stretch predictor or typed bytes.
// Depends on smmn_pkg and the block under rtl/core.
module tb_slice_minmax_normalizer_unit;
   import smmn_pkg::*;

   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 230;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic {
      ROW_REQ,
      ROW_CFG
   } row_kind_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } byte_result_type;

   typedef struct {
      row_kind_type            kind;
      cmd_type                 cmd;
      logic signed [PIX_W-1:0] pixel;
      logic                    slice_end;
      bit                      typed;
      byte_result_type         want;
      reg_index_type           reg_idx;
      logic [BYTE_W-1:0]       reg_val;
   } stim_row_type;

   logic                    clock;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_ready;
   logic                    req_cmd       = 1'b0;
   logic signed [PIX_W-1:0] req_pixel     = '0;
   logic                    req_slice_end = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready     = 1'b0;
   logic [BYTE_W-1:0]       rsp_out_byte;
   logic                    rsp_out_last;
   logic                    psel          = 1'b0;
   logic                    penable       = 1'b0;
   logic                    pwrite        = 1'b0;
   logic [ADDR_W-1:0]       paddr         = '0;
   logic [DATA_W-1:0]       pwdata        = '0;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   slice_minmax_normalizer_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pixel     (req_pixel),
      .req_slice_end (req_slice_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // predictor state
   logic [BYTE_W-1:0]        cfg_out_min   = OUT_MIN_RST;
   logic [BYTE_W-1:0]        cfg_out_max   = OUT_MAX_RST;
   logic signed [PIX_W-1:0]  track_min     = RUN_MIN_INIT;
   logic signed [PIX_W-1:0]  track_max     = RUN_MAX_INIT;
   logic [PIX_W-1:0]         lat_divisor   = '0;
   logic signed [PIX_W-1:0]  lat_min       = '0;
   logic                     lat_blank     = 1'b1;
   logic signed [SPAN_W-1:0] lat_span      = '0;
   logic [BYTE_W-1:0]        lat_out_min   = '0;

   byte_result_type pending_bytes[$];
   stim_row_type    dir_table[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int failures      = 0;
   int n_requests    = 0;
   int n_results     = 0;
   int n_slices      = 0;
   int n_cfg_writes  = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(4_000_000);
      $display("timeout: %0d responses still outstanding", pending_bytes.size());
      $display("TEST FAILED");
      $finish;
   end

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("mismatch: %s", msg);
   endfunction

   function automatic stim_row_type req_row(cmd_type cmd, logic signed [PIX_W-1:0] pix,
                                            logic last, bit typed, byte_result_type want);
      stim_row_type r;
      r.kind      = ROW_REQ;
      r.cmd       = cmd;
      r.pixel     = pix;
      r.slice_end = last;
      r.typed     = typed;
      r.want      = want;
      r.reg_idx   = REG_OUT_MIN;
      r.reg_val   = '0;
      return r;
   endfunction

   function automatic stim_row_type cfg_row(reg_index_type idx, logic [BYTE_W-1:0] val);
      stim_row_type r;
      r           = req_row(CMD_ACCUM, '0, 1'b0, 1'b0, '0);
      r.kind      = ROW_CFG;
      r.reg_idx   = idx;
      r.reg_val   = val;
      return r;
   endfunction

   // One request through the stretch: pass one tracks extremes and latches the
   // slice on its end, pass two yields trunc(omin + 0.5 + d * span / divisor).
   task automatic stretch_predict(input cmd_type cmd, input logic signed [PIX_W-1:0] pix,
                                  input logic last, output bit has_rsp,
                                  output byte_result_type res);
      longint diff, den, num, quot;
      has_rsp = 1'b0;
      res     = '0;
      if (cmd == CMD_ACCUM) begin
         if (pix < track_min) track_min = pix;
         if (pix > track_max) track_max = pix;
         if (last) begin
            lat_min     = track_min;
            lat_out_min = cfg_out_min;
            lat_span    = $signed({1'b0, cfg_out_max}) - $signed({1'b0, cfg_out_min});
            lat_blank   = (track_max == track_min);
            lat_divisor = lat_blank ? '0
                          : PIX_W'(longint'(track_max) - longint'(track_min));
            track_min   = RUN_MIN_INIT;
            track_max   = RUN_MAX_INIT;
         end
      end else begin
         has_rsp  = 1'b1;
         res.last = last;
         if (lat_blank || lat_divisor == 0) begin
            res.value = lat_out_min;
         end else begin
            diff = longint'(pix) - longint'(lat_min);
            den  = 2 * longint'(lat_divisor);
            num  = (2 * longint'(lat_out_min) + 1) * longint'(lat_divisor)
                   + 2 * diff * longint'(lat_span);
            quot = num / den;   // truncates toward zero
            res.value = quot[BYTE_W-1:0];
         end
      end
   endtask

   task automatic send_request(input cmd_type cmd, input logic signed [PIX_W-1:0] pix,
                               input logic last, input bit typed,
                               input byte_result_type want);
      bit              has_rsp;
      byte_result_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_pixel     <= pix;
      req_slice_end <= last;
      do @(posedge clock); while (!req_ready);
      stretch_predict(cmd, pix, last, has_rsp, res);
      if (has_rsp)
         pending_bytes.push_back(typed ? want : res);
      n_requests++;
   endtask

   // Drop valid and hold until every outstanding response has come back.
   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // Write one range register while the block is idle, then read it back.
   task automatic program_range(input reg_index_type idx, input logic [BYTE_W-1:0] val);
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] rd;
      addr = ADDR_W'(idx) << 2;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= DATA_W'(val);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_OUT_MIN) cfg_out_min = val;
      else cfg_out_max = val;
      n_cfg_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      if (rd !== DATA_W'(val))
         note_failure($sformatf("readback of register %s: expected %0d, got %0d",
                                idx.name(), val, rd));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // One well-formed slice: a pass of accumulate requests ending on slice_end,
   // then an emit pass. Sizes stay small with an occasional long slice.
   task automatic random_slice();
      int                      n_acc, n_emit, shape;
      logic signed [PIX_W-1:0] base, pix;
      logic [PIX_W-1:0]        mask;
      shape = $urandom_range(9);
      base  = $urandom;
      if (shape < 2) mask = '1;
      else if (shape == 2) mask = '0;
      else mask = {PIX_W{1'b1}} >> $urandom_range(PIX_W - 1);
      n_acc  = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      n_emit = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      for (int i = 0; i < n_acc; i++)
         send_request(CMD_ACCUM, base + PIX_W'($urandom & mask), i == n_acc - 1, 1'b0, '0);
      for (int i = 0; i < n_emit; i++) begin
         // some emit pixels fall outside the slice range
         pix = ($urandom_range(7) == 0) ? PIX_W'($urandom) : base + PIX_W'($urandom & mask);
         send_request(CMD_EMIT, pix, i == n_emit - 1, 1'b0, '0);
      end
      n_slices++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      byte_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_bytes.size() == 0) begin
            note_failure($sformatf("response byte %0d last %0d with no request pending",
                                   rsp_out_byte, rsp_out_last));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.value || rsp_out_last !== want.last)
               note_failure($sformatf("response: expected byte %0d last %0d, got byte %0d last %0d",
                                      want.value, want.last, rsp_out_byte, rsp_out_last));
         end
      end
   end

   initial begin
      int            phase_start;
      bit            paused;
      idle_mode_type mode;
      logic [BYTE_W-1:0] lo, hi;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // emit before any slice, full-scale slice, blank slice, reversed range,
      // out-of-range pixels, zero span
      dir_table.push_back(req_row(CMD_EMIT,  32'sh0,        1'b1, 1'b1, {8'd0,   1'b1}));
      dir_table.push_back(req_row(CMD_EMIT,  32'sh7FFFFFFF, 1'b0, 1'b1, {8'd0,   1'b0}));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sh80000000, 1'b0, 1'b0, '0));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sh7FFFFFFF, 1'b0, 1'b0, '0));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sh0,        1'b1, 1'b0, '0));
      dir_table.push_back(req_row(CMD_EMIT,  32'sh80000000, 1'b0, 1'b1, {8'd0,   1'b0}));
      dir_table.push_back(req_row(CMD_EMIT,  32'sh7FFFFFFF, 1'b0, 1'b1, {8'd255, 1'b0}));
      dir_table.push_back(req_row(CMD_EMIT,  32'sh0,        1'b1, 1'b0, '0));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sh00050000, 1'b0, 1'b0, '0));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sh00050000, 1'b1, 1'b0, '0));
      dir_table.push_back(req_row(CMD_EMIT,  32'sd123,      1'b0, 1'b1, {8'd0,   1'b0}));
      dir_table.push_back(req_row(CMD_EMIT,  -32'sd7,       1'b1, 1'b1, {8'd0,   1'b1}));
      dir_table.push_back(cfg_row(REG_OUT_MIN, 8'd200));
      dir_table.push_back(cfg_row(REG_OUT_MAX, 8'd10));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sd100,      1'b0, 1'b0, '0));
      dir_table.push_back(req_row(CMD_ACCUM, -32'sd100,     1'b1, 1'b0, '0));
      dir_table.push_back(req_row(CMD_EMIT,  -32'sd100,     1'b0, 1'b1, {8'd200, 1'b0}));
      dir_table.push_back(req_row(CMD_EMIT,  32'sd100,      1'b0, 1'b1, {8'd10,  1'b0}));
      dir_table.push_back(req_row(CMD_EMIT,  32'sd1000,     1'b1, 1'b0, '0));
      dir_table.push_back(cfg_row(REG_OUT_MIN, 8'd255));
      dir_table.push_back(cfg_row(REG_OUT_MAX, 8'd255));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sd3,        1'b0, 1'b0, '0));
      dir_table.push_back(req_row(CMD_ACCUM, 32'sd9,        1'b1, 1'b0, '0));
      dir_table.push_back(req_row(CMD_EMIT,  32'sd9,        1'b0, 1'b1, {8'd255, 1'b0}));
      dir_table.push_back(req_row(CMD_EMIT,  32'sh80000000, 1'b1, 1'b0, '0));

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CFG)
            program_range(dir_table[i].reg_idx, dir_table[i].reg_val);
         else
            send_request(dir_table[i].cmd, dir_table[i].pixel, dir_table[i].slice_end,
                         dir_table[i].typed, dir_table[i].want);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         lo = BYTE_W'($urandom);
         hi = BYTE_W'($urandom);
         case (phase)
            0: begin lo = 8'd0;   hi = 8'd255; end
            1: begin lo = 8'd255; hi = 8'd0;   end
            2: hi = lo;
            3: begin lo = 8'd0;   hi = 8'd0;   end
            default: ;
         endcase
         program_range(REG_OUT_MIN, lo);
         program_range(REG_OUT_MAX, hi);

         mode = idle_mode_type'(phase % 4);
         case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 49; rsp_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  rsp_stall_pct = 49; end
            default:   begin send_idle_pct = 19; rsp_stall_pct = 19; end
         endcase

         phase_start = n_requests;
         paused      = 1'b0;
         while (n_requests - phase_start < PHASE_ITEMS) begin
            if (!paused && n_requests - phase_start >= PHASE_ITEMS / 2) begin
               wait_results();
               paused = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
               // noise: commands and slice ends in any order
               repeat ($urandom_range(1, 4))
                  send_request(cmd_type'($urandom_range(1)), PIX_W'($urandom),
                               1'($urandom_range(1)), 1'b0, '0);
            end else begin
               random_slice();
            end
         end
      end

      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d responses: %0d random slices, %0d range writes,",
               n_requests, n_results, n_slices, n_cfg_writes);
      $display("blank and reversed ranges, out-of-range pixels, four idle/stall mixes");
      if (failures == 0 && pending_bytes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures, %0d responses missing", failures, pending_bytes.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
